// ===== src/i2cm_pkg.sv =====
package i2cm_pkg;

    typedef enum logic [4:0] {
        S_IDLE, S_ST0, S_ST1, S_ST2, S_TXL, S_TXH, S_TA0, S_TA1, S_TA2,
        S_RG0, S_RG1, S_RG2, S_RXL, S_RXH, S_RXE, S_MA0, S_MA1, S_MA2,
        S_SP0, S_SP1, S_SP2, S_SP3, S_WAIT
    } t_step;

    typedef enum logic [1:0] {
        ROLE_ADDR, ROLE_REG, ROLE_RADDR, ROLE_DATA
    } t_role;

    typedef enum logic [1:0] {
        F_TICK  = 2'd0,
        F_WRITE = 2'd1,
        F_READ  = 2'd2,
        F_PUSH  = 2'd3
    } t_func;

    localparam int unsigned CfgIdxW   = 1;
    localparam int unsigned CfgDataW  = 8;
    localparam logic [CfgIdxW-1:0] CFG_DEVICE_ADDRESS = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_PHASE_TICKS    = 1'd1;
    localparam logic [7:0] PHASE_TICKS_RESET = 8'd6;
    localparam int unsigned QDepth = 2;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] reg_address;
        logic [8:0] byte_count;
        logic [7:0] write_byte;
        logic       sda_level;
    } t_cmd;

    typedef struct packed {
        logic       scl_drive;
        logic       sda_drive;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       byte_wanted;
        logic       busy_res;
        logic       done_res;
        logic       nack_seen;
    } t_res;

endpackage

// ===== src/i2cm_stream_if.sv =====
interface i2cm_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/i2cm_cmd_queue.sv =====
// Front part: two-entry queue of accepted command beats.
module i2cm_cmd_queue
    import i2cm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    i2cm_stream_if.sink   s_in,
    input  logic          i_pop,
    output logic          o_valid,
    output t_cmd          o_cmd
);
    t_cmd       r_mem [QDepth];
    logic       r_wp, r_rp, n_wp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push, pop;

    assign s_in.ready = (r_cnt != 2'(QDepth));
    assign push = s_in.valid && s_in.ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop = i_pop && o_valid;
    assign o_cmd = r_mem[r_rp];

    always_comb begin
        n_wp = push ? ~r_wp : r_wp;
        n_rp = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
        if (push) r_mem[r_wp] <= s_in.data;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QDepth)) else $error("queue overfill");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'(QDepth) |-> !push) else $error("push when full");
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> r_cnt == $past(r_cnt) - 2'd1) else $error("count slip");
endmodule

// ===== src/i2cm_engine.sv =====
// Back part: bus sequencer, one command beat per cycle while the output does not stall, result into output register.
module i2cm_engine
    import i2cm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic       i_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    i2cm_stream_if.source m_out
);
    logic [6:0] r_dev;
    logic [7:0] r_ticks;
    t_step      r_step, n_step;
    logic [7:0] r_pc, n_pc;
    logic [3:0] r_bc, n_bc;
    logic [7:0] r_sh, n_sh;
    logic [8:0] r_left, n_left;
    logic [7:0] r_hb, n_hb;
    logic       r_hv, n_hv, r_rd, n_rd, r_nack, n_nack, r_scl, n_scl, r_sda, n_sda;
    logic [7:0] r_reg, n_reg;
    t_role      r_role, n_role;
    logic       r_ov;
    t_res       r_res, n_res;
    logic       go, rv, dn, endp, want;
    logic [7:0] limit, pc1;

    assign o_pop = go;
    assign go = i_valid && (!r_ov || m_out.ready);
    assign m_out.valid = r_ov;
    assign m_out.data = r_res;
    assign limit = (r_ticks == 8'd0) ? 8'd1 : r_ticks;
    assign pc1 = r_pc + 8'd1;

    always_comb begin
        n_step = r_step; n_pc = r_pc; n_bc = r_bc; n_sh = r_sh; n_left = r_left;
        n_hb = r_hb; n_hv = r_hv; n_rd = r_rd; n_nack = r_nack; n_scl = r_scl;
        n_sda = r_sda; n_reg = r_reg; n_role = r_role;
        rv = 1'b0; dn = 1'b0; endp = 1'b0;
        case (t_func'(i_cmd.func))
            F_TICK: begin
                if (r_step == S_WAIT) begin
                    if (r_hv) begin
                        n_sh = r_hb; n_hv = 1'b0;
                        if (r_left != 9'd0) n_left = r_left - 9'd1;
                        n_role = ROLE_DATA; n_bc = 4'd0; n_step = S_TXL;
                    end
                end else if (r_step != S_IDLE) begin
                    if (pc1 >= limit) endp = 1'b1; else n_pc = pc1;
                end
            end
            F_PUSH: begin
                if (r_step != S_IDLE && !r_rd && r_left != 9'd0 && !r_hv) begin
                    n_hb = i_cmd.write_byte; n_hv = 1'b1;
                end
            end
            default: begin
                if (r_step == S_IDLE) begin
                    n_rd = (i_cmd.func == F_READ);
                    n_reg = i_cmd.reg_address;
                    n_left = (n_rd && i_cmd.byte_count == 9'd0) ? 9'd1 : i_cmd.byte_count;
                    n_hv = 1'b0; n_nack = 1'b0; n_role = ROLE_ADDR; n_bc = 4'd0;
                    n_step = S_ST0;
                end
            end
        endcase
        if (endp) begin
            case (r_step)
                S_ST0: n_step = S_ST1;
                S_ST1: n_step = S_ST2;
                S_ST2: begin
                    n_sh = {r_dev, r_role == ROLE_RADDR}; n_bc = 4'd0; n_step = S_TXL;
                end
                S_TXL: n_step = S_TXH;
                S_TXH: begin
                    n_bc = r_bc + 4'd1;
                    n_step = (n_bc < 4'd8) ? S_TXL : S_TA0;
                end
                S_TA0: n_step = S_TA1;
                S_TA1: n_step = S_TA2;
                S_TA2: begin
                    if (i_cmd.sda_level) n_nack = 1'b1;
                    if (r_role == ROLE_ADDR) begin
                        n_sh = r_reg; n_role = ROLE_REG; n_bc = 4'd0; n_step = S_TXL;
                    end else if (r_role == ROLE_REG && r_rd) begin
                        n_step = S_RG0;
                    end else if (r_role == ROLE_RADDR) begin
                        n_sh = 8'd0; n_bc = 4'd0; n_step = S_RXL;
                    end else if (r_left == 9'd0) begin
                        n_step = S_SP0;
                    end else if (r_hv) begin
                        n_sh = r_hb; n_hv = 1'b0; n_left = r_left - 9'd1;
                        n_role = ROLE_DATA; n_bc = 4'd0; n_step = S_TXL;
                    end else begin
                        n_step = S_WAIT;
                    end
                end
                S_RG0: n_step = S_RG1;
                S_RG1: n_step = S_RG2;
                S_RG2: begin n_role = ROLE_RADDR; n_step = S_ST0; end
                S_RXL: n_step = S_RXH;
                S_RXH: begin
                    n_sh = {r_sh[6:0], i_cmd.sda_level};
                    n_bc = r_bc + 4'd1;
                    if (n_bc < 4'd8) begin
                        n_step = S_RXL;
                    end else begin
                        rv = 1'b1;
                        if (r_left != 9'd0) n_left = r_left - 9'd1;
                        n_step = S_RXE;
                    end
                end
                S_RXE: n_step = S_MA0;
                S_MA0: n_step = S_MA1;
                S_MA1: n_step = S_MA2;
                S_MA2: begin
                    if (r_left != 9'd0) begin
                        n_sh = 8'd0; n_bc = 4'd0; n_step = S_RXL;
                    end else begin
                        n_step = S_SP0;
                    end
                end
                S_SP0: n_step = S_SP1;
                S_SP1: n_step = S_SP2;
                S_SP2: n_step = S_SP3;
                S_SP3: begin n_step = S_IDLE; dn = 1'b1; end
                default: n_step = S_IDLE;
            endcase
        end
        // pin levels on phase entry
        if (n_step != r_step || endp || (r_step == S_WAIT && n_step == S_TXL)
            || (r_step == S_IDLE && n_step == S_ST0)) begin
            n_pc = 8'd0;
            case (n_step)
                S_ST0: begin n_scl = 1'b1; n_sda = 1'b1; end
                S_ST1: n_sda = 1'b0;
                S_ST2: n_scl = 1'b0;
                S_TXL: begin n_scl = 1'b0; n_sda = n_sh[3'd7 - n_bc[2:0]]; end
                S_TXH: n_scl = 1'b1;
                S_TA0: n_scl = 1'b0;
                S_TA1: n_sda = 1'b1;
                S_TA2: n_scl = 1'b1;
                S_RG1: n_scl = 1'b0;
                S_RXL: begin n_scl = 1'b0; n_sda = 1'b1; end
                S_RXH: n_scl = 1'b1;
                S_RXE: n_scl = 1'b0;
                S_MA0: n_sda = (n_left != 9'd0) ? 1'b0 : 1'b1;
                S_MA1: n_scl = 1'b1;
                S_MA2: n_scl = 1'b0;
                S_SP0: n_scl = 1'b0;
                S_SP1: n_sda = 1'b0;
                S_SP2: n_scl = 1'b1;
                S_SP3: n_sda = 1'b1;
                default: ;
            endcase
        end
        want = (n_step != S_IDLE) && !n_rd && (n_left != 9'd0) && !n_hv;
        n_res.scl_drive = n_scl;
        n_res.sda_drive = n_sda;
        n_res.read_byte = rv ? n_sh : 8'd0;
        n_res.read_valid = rv;
        n_res.byte_wanted = want;
        n_res.busy_res = (n_step != S_IDLE);
        n_res.done_res = dn;
        n_res.nack_seen = n_nack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev <= 7'd0; r_ticks <= PHASE_TICKS_RESET;
            r_step <= S_IDLE; r_pc <= 8'd0; r_bc <= 4'd0; r_sh <= 8'd0;
            r_left <= 9'd0; r_hb <= 8'd0; r_hv <= 1'b0; r_rd <= 1'b0;
            r_reg <= 8'd0; r_nack <= 1'b0; r_scl <= 1'b1; r_sda <= 1'b1;
            r_role <= ROLE_ADDR; r_ov <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEVICE_ADDRESS: r_dev <= i_cfg_data[6:0];
                    CFG_PHASE_TICKS:    r_ticks <= i_cfg_data;
                    default: ;
                endcase
            end
            if (go) begin
                r_step <= n_step; r_pc <= n_pc; r_bc <= n_bc; r_sh <= n_sh;
                r_left <= n_left; r_hb <= n_hb; r_hv <= n_hv; r_rd <= n_rd;
                r_reg <= n_reg; r_nack <= n_nack; r_scl <= n_scl; r_sda <= n_sda;
                r_role <= n_role;
            end
            if (go) r_ov <= 1'b1;
            else if (m_out.ready) r_ov <= 1'b0;
        end
        if (go) r_res <= n_res;
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_out.ready) |=> r_ov && $stable(r_res)) else $error("result lost");
    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == S_IDLE |-> r_scl && r_sda) else $error("bus not released");
    a_bc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bc <= 4'd8) else $error("bit counter overrun");
endmodule

// ===== src/i2c_register_access_master.sv =====
// I2C register read/write master.
// s_cmd carries command beats: func (tick, begin write, begin read, push byte),
// reg_address, byte_count, write_byte and the sampled sda_level. Each beat
// gives exactly one result beat on m_res: pin levels scl_drive/sda_drive,
// read_byte/read_valid, byte_wanted, busy_res, done_res and sticky nack_seen.
// A tick advances the phase counter; each bus phase lasts phase_ticks ticks (0 acts as 1).
// Config writes (index 0 device_address, 1 phase_ticks) are taken at any
// edge with i_cfg_we high and should be issued while idle.
// Throughput is one beat per cycle while m_res does not stall; the sequencer
// takes one step per beat. A beat accepted on s_cmd enters the two-entry queue;
// its result is then registered in the output register and visible from then on.
// When m_res stalls, the result register holds and the queue keeps taking
// beats; s_cmd.ready drops once the queue holds two beats; nothing is lost.
// Synchronous reset: pins released high, sequencer idle, queue empty,
// phase_ticks back to 6, device_address 0.
module i2c_register_access_master
    import i2cm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    i2cm_stream_if.sink   s_cmd,
    i2cm_stream_if.source m_res
);
    logic q_valid, q_pop;
    t_cmd q_cmd;

    i2cm_cmd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(s_cmd),
        .i_pop(q_pop), .o_valid(q_valid), .o_cmd(q_cmd)
    );

    i2cm_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(q_valid), .i_cmd(q_cmd), .o_pop(q_pop), .m_out(m_res)
    );
endmodule
